### rtl/twrdm_pkg.sv
// Package for the ranging distance median filter: widths, register map, states.
// No dependencies.
`timescale 1ns / 1ps
package twrdm_pkg;
    localparam int TS_W        = 32;
    localparam int DIST_W      = 16;
    localparam int SCALE_W     = 24;
    localparam int PEER_W      = 3;
    localparam int HIST_DEPTH  = 3;
    localparam int DEF_PEERS   = 8;
    localparam int PROD_W      = 64;
    localparam int DEN_W       = 34;

    localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd307479;
    localparam logic [DIST_W-1:0]  OFFSET_RST = 16'd1000;
    localparam logic [DIST_W-1:0]  THRESH_RST = 16'd500;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_OFFSET = 2'd1,
        REG_THRESH = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_FILT,
        ST_OUT
    } state_t;

    function automatic logic [DIST_W-1:0] mid3(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b,
                                               input logic [DIST_W-1:0] c);
        logic [DIST_W-1:0] r;
        if (a <= b && a <= c)      r = (b <= c) ? b : c;
        else if (b <= a && b <= c) r = (a <= c) ? a : c;
        else                       r = (a <= b) ? a : b;
        return r;
    endfunction
endpackage

### rtl/twr_distance_median_filter.sv
// Top level: ranging distance from timestamps plus per-peer median filter.
// Depends on twrdm_pkg, twrdm_serial_mul, twrdm_serial_div.
`timescale 1ns / 1ps
// Usage:
//  - Input stream s_*: one beat per command. tuser = {peer_index, command}
//    (command bit 0). tdata carries six 32-bit timestamps then the reported
//    distance (208 bits). Result stream m_*: tuser = peer_out, tdata =
//    {updated, filtered_distance, raw_distance}, padded to 40 bits.
//  - APB port: reg 0 mm_per_tick_q16 at 0x0, reg 1 offset_mm at 0x4,
//    reg 2 outlier_threshold_mm at 0x8. pready is always high.
//  - Command 0: two 32-step products, a 64-step divide, a 32-step scale
//    multiply, then filter and output. A zero divisor skips divide and scale.
//    A zero or huge quotient, or zero scale, skips the scale multiply.
//    Command 1: the reported distance goes straight to filter and output.
//    One item at a time; the next beat can be accepted in the cycle after
//    the result beat is taken.
//  - s_tready is high only when idle; a result waits in the output register
//    while m_tready is low and the next item is held off until it is taken.
//  - Reset clears history, insert positions, stored distances and restores
//    register defaults; no clearing pass (all state is in flip-flops).
module twr_distance_median_filter import twrdm_pkg::*; #(
    parameter int PEERS = DEF_PEERS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // poll_sent, answer_received, final_sent,
                                    // poll_received, answer_sent, final_received,
                                    // reported_distance
    input  logic [3:0]   s_tuser,   // command, peer_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // raw_distance, filtered_distance, updated, pad
    output logic [2:0]   m_tuser,   // peer_out
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int PIW = (PEERS > 1) ? $clog2(PEERS) : 1;

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [DIST_W-1:0]  offset_reg, thresh_reg;
    logic               wr_en;
    reg_idx_t           widx;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_RST;
            offset_reg <= OFFSET_RST;
            thresh_reg <= THRESH_RST;
        end else if (wr_en) begin
            unique case (widx)
                REG_SCALE:  scale_reg  <= pwdata[SCALE_W-1:0];
                REG_OFFSET: offset_reg <= pwdata[DIST_W-1:0];
                REG_THRESH: thresh_reg <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_SCALE:  prdata = {8'd0, scale_reg};
            REG_OFFSET: prdata = {16'd0, offset_reg};
            REG_THRESH: prdata = {16'd0, thresh_reg};
            default:    prdata = '0;
        endcase
    end

    // input capture
    logic [TS_W-1:0] round1_reg, round2_reg, reply1_reg, reply2_reg;
    logic [DIST_W-1:0] rep_reg;
    logic [PEER_W-1:0] peer_reg;
    logic              cmd_reg;
    logic              in_acc;
    assign in_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg    <= s_tuser[0];
            peer_reg   <= s_tuser[3:1];
            round1_reg <= s_tdata[63:32]   - s_tdata[31:0];
            reply1_reg <= s_tdata[159:128] - s_tdata[127:96];
            round2_reg <= s_tdata[191:160] - s_tdata[159:128];
            reply2_reg <= s_tdata[95:64]   - s_tdata[63:32];
            rep_reg    <= s_tdata[207:192];
        end
    end

    // state machine
    state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;   // 0: prod1, 1: prod2, 2: scale

    logic              mul_start, mul_done;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic              div_start, div_done;
    logic [63:0]       div_q;
    logic [63:0]       prod1_reg;
    logic              neg_reg;
    logic [63:0]       mag_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIST_W-1:0] raw_reg;
    logic [63:0]       q_reg;

    twrdm_serial_mul #(.AW(32), .BW(32)) u_mul (
        .aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .p(mul_p)
    );
    twrdm_serial_div #(.NW(64), .DW(DEN_W)) u_div (
        .aclk, .aresetn, .start(div_start), .num(mag_reg), .den(den_reg),
        .done(div_done), .quo(div_q)
    );

    always_comb begin
        unique case (phase_reg)
            2'd0:    begin mul_a = round1_reg; mul_b = round2_reg; end
            2'd1:    begin mul_a = reply1_reg; mul_b = reply2_reg; end
            default: begin mul_a = q_reg[31:0]; mul_b = {8'd0, scale_reg}; end
        endcase
    end

    logic start_pulse_reg;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) begin
                state_next = s_tuser[0] ? ST_FILT : ST_MUL;
                phase_next = 2'd0;
            end
            ST_MUL: if (mul_done) begin
                if (phase_reg == 2'd0) phase_next = 2'd1;
                else                   state_next = ST_DIV;
            end
            ST_DIV: if (div_done || den_reg == '0) state_next = ST_SCALE;
            ST_SCALE: if (den_reg == '0 || q_reg == '0 || scale_reg == '0
                          || q_reg[63:32] != '0 || mul_done) state_next = ST_FILT;
            ST_FILT: state_next = ST_OUT;
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_start = start_pulse_reg && (state_reg == ST_MUL || state_reg == ST_SCALE);
        div_start = start_pulse_reg && (state_reg == ST_DIV) && den_reg != '0;
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 2'd0;
            start_pulse_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= (state_next == ST_SCALE) ? 2'd2 : phase_next;
            start_pulse_reg <= (state_next != state_reg) || (phase_next != phase_reg);
        end
    end

    // datapath registers
    logic [56:0] sum_pos;
    logic [57:0] base_w;
    assign base_w  = {26'd0, offset_reg, 16'd0};
    assign sum_pos = 57'(base_w) + 57'(mul_p);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL && phase_reg == 2'd0 && state_next == ST_MUL
            && start_pulse_reg) begin
            den_reg <= 34'(round1_reg) + 34'(round2_reg) + 34'(reply1_reg)
                       + 34'(reply2_reg);
        end
        if (state_reg == ST_MUL && mul_done) begin
            if (phase_reg == 2'd0) prod1_reg <= mul_p;
            else begin
                neg_reg <= prod1_reg < mul_p;
                mag_reg <= (prod1_reg < mul_p) ? mul_p - prod1_reg : prod1_reg - mul_p;
            end
        end
        if (state_reg == ST_DIV && div_done) q_reg <= div_q;
        if (state_reg == ST_IDLE && in_acc) q_reg <= '0;
        if (state_reg == ST_SCALE && state_next == ST_FILT) begin
            if (den_reg == '0)
                raw_reg <= '0;
            else if (q_reg[63:32] != '0)
                raw_reg <= neg_reg ? 16'd0 : 16'hFFFF;
            else if (q_reg == '0 || scale_reg == '0)
                raw_reg <= offset_reg;
            else if (neg_reg)
                raw_reg <= (mul_p[55:0] >= base_w[55:0]) ? 16'd0
                         : 16'(base_w[31:16] - mul_p[31:16]
                               - 16'(base_w[15:0] < mul_p[15:0]));
            else
                raw_reg <= (sum_pos[56:32] != '0) ? 16'hFFFF : sum_pos[31:16];
        end
        if (state_reg == ST_IDLE && in_acc && s_tuser[0]) raw_reg <= s_tdata[207:192];
    end

    // filter tables
    logic [DIST_W-1:0] hist_reg [PEERS][HIST_DEPTH];
    logic [1:0]        pos_reg  [PEERS];
    logic [DIST_W-1:0] dist_reg [PEERS];
    logic [DIST_W-1:0] filt_reg;
    logic              upd_reg;
    logic              peer_ok;
    logic [PIW-1:0]    pi;
    logic [DIST_W-1:0] med, gap;
    logic [1:0]        npos;

    assign peer_ok = 32'(peer_reg) < PEERS;
    assign pi      = PIW'(peer_reg);
    assign med     = mid3(hist_reg[pi][0], hist_reg[pi][1], hist_reg[pi][2]);
    assign gap     = (med > raw_reg) ? med - raw_reg : raw_reg - med;
    assign npos    = (pos_reg[pi] == 2'd2) ? 2'd0 : pos_reg[pi] + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PEERS; i++) begin
                pos_reg[i]  <= '0;
                dist_reg[i] <= '0;
                for (int j = 0; j < HIST_DEPTH; j++) hist_reg[i][j] <= '0;
            end
            upd_reg <= 1'b0;
        end else if (state_reg == ST_FILT) begin
            upd_reg <= peer_ok && raw_reg != '0;
            if (peer_ok && raw_reg != '0) begin
                dist_reg[pi]       <= (gap > thresh_reg) ? med : raw_reg;
                pos_reg[pi]        <= npos;
                hist_reg[pi][npos] <= raw_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILT)
            filt_reg <= !peer_ok ? '0
                      : (raw_reg != '0) ? ((gap > thresh_reg) ? med : raw_reg)
                      : dist_reg[pi];
    end

    assign m_tuser = peer_reg;
    assign m_tdata = {7'd0, upd_reg, filt_reg, raw_reg};

    ap_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("both sides open");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out hold");
    ap_upd_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[15:0] != '0) else $error("upd zero");
    ap_pos_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg[pi] != 2'd3) else $error("pos range");
endmodule

### rtl/twrdm_serial_mul.sv
// Bit-serial unsigned multiplier: one multiplier bit per cycle, shift-add.
// Depends on twrdm_pkg.
`timescale 1ns / 1ps
module twrdm_serial_mul import twrdm_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic              done,
    output logic [AW+BW-1:0]  p
);
    localparam int CW = $clog2(BW + 1);
    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0]    mplier_reg, mplier_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = busy_reg && (cnt_reg == CW'(1)) && !start;
        if (start) begin
            acc_next    = '0;
            mcand_next  = {{BW{1'b0}}, a};
            mplier_next = b;
            cnt_next    = CW'(BW);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // done rises once the last add is registered, so p is the full product
    assign done = done_reg && !start;
    assign p    = acc_reg;

    ap_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0 || !$past(busy_reg)) else $error("mul count");
    ap_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg) else $error("mul done");
    ap_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0) else $error("mul busy");
endmodule

### rtl/twrdm_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on twrdm_pkg.
`timescale 1ns / 1ps
module twrdm_serial_div import twrdm_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 34
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [DW:0]    rem_reg, rem_next;
    logic [NW-1:0]  q_reg, q_next;
    logic [DW-1:0]  d_reg, d_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DW+1:0]  trial;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == CW'(1)) && !start;
        trial     = {rem_reg, q_reg[NW-1]} - {2'b0, d_reg};
        if (start) begin
            rem_next  = '0;
            q_next    = num;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DW+1]) begin
                rem_next = trial[DW:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DW-1:0], q_reg[NW-1]};
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    // done rises once the last quotient bit is registered
    assign done = done_reg && !start;
    assign quo  = q_reg;

    ap_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0) else $error("div busy");
    ap_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg) else $error("div done");
    ap_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && $past(busy_reg) |-> rem_reg < {1'b0, d_reg}) else $error("div rem");
endmodule
